### rtl/core/pba_pkg.sv
package pba_pkg;

   // Geometry of the page map and the address space.
   localparam int MAX_PAGES  = 4096;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int CNT_W      = PAGE_W + 1;
   localparam int ADDR_W     = 48;
   localparam int SUM_W      = ADDR_W + 1;
   localparam int BIGPG_W    = SUM_W - PAGE_SHIFT;
   localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

   // Configuration port geometry.
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register indexes.
   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_TOTAL      = 2'd1;
   localparam logic [1:0] REG_RSV_FIRST  = 2'd2;
   localparam logic [1:0] REG_RSV_COUNT  = 2'd3;

   // Operation codes.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // One entry of the page map.
   typedef struct packed {
      logic used;
      logic managed;
   } page_entry_type;

   localparam int ENTRY_W = $bits(page_entry_type);

   // Configuration registers as seen by the engine.
   typedef struct packed {
      logic                enable;
      logic [CNT_W-1:0]    total_pages;
      logic [PAGE_W-1:0]   reserved_first_page;
      logic [CNT_W-1:0]    reserved_page_count;
   } cfg_type;

   // Access to the page map memory.
   typedef struct packed {
      logic                rd_en;
      logic [PAGE_W-1:0]   rd_addr;
      logic                wr_en;
      logic [PAGE_W-1:0]   wr_addr;
      page_entry_type      wr_data;
   } mem_req_type;

endpackage

### rtl/core/pba_req_if.sv
interface pba_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [pba_pkg::ADDR_W-1:0]   byte_address;
   logic [pba_pkg::ADDR_W-1:0]   region_length;
   logic [pba_pkg::CNT_W-1:0]    page_request;

   modport source (output valid, opcode, byte_address, region_length, page_request,
                   input ready);
   modport sink (input valid, opcode, byte_address, region_length, page_request,
                 output ready);
endinterface

### rtl/core/pba_rsp_if.sv
interface pba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [pba_pkg::ADDR_W-1:0]   result_address;
   logic                         page_used;
   logic [pba_pkg::CNT_W-1:0]    pages_free;
   logic [pba_pkg::CNT_W-1:0]    pages_managed;
   logic [pba_pkg::CNT_W-1:0]    pages_in_use;

   modport source (output valid, ok, result_address, page_used, pages_free,
                   pages_managed, pages_in_use, input ready);
   modport sink (input valid, ok, result_address, page_used, pages_free,
                 pages_managed, pages_in_use, output ready);
endinterface

### rtl/core/page_bitmap_next_fit_allocator.sv
// Physical page allocator over a map of used and managed bits, one entry per page.
// The request channel carries an opcode (add region, allocate, free, query), a byte
// address, a region length and a page count; each request gives exactly one transfer
// on the response channel with the status, the allocated address, the query answer
// and the free, managed and used page counts.
// Configuration is to be written through the APB-style port while no request is in
// flight; the block itself does not enforce this. A disabled or rejected request
// goes straight to its response, and a query reads its one map entry. Add region and
// free read and check each page in turn (map read, then update); free then writes
// back each released page. Allocate scans page by page over up to the whole map,
// then marks the run page by page. The page-map memory with its registered read
// sets this pace; one request is in service at a time.
// After reset the map is cleared to "used, unmanaged" one entry per cycle, over the
// whole map; req_chan.ready stays low until then.
// The response sits in an output register; a new request is accepted while it waits,
// and the next response is held back until the receiver has taken the previous one.
module page_bitmap_next_fit_allocator (
   input  logic                         clock,
   input  logic                         reset,
   pba_req_if.sink                      req_chan,
   pba_rsp_if.source                    rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pba_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pba_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pba_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   pba_pkg::cfg_type                cfg;
   pba_pkg::mem_req_type            mem;
   logic [pba_pkg::ENTRY_W-1:0]     mem_rd_data;

   // Configuration registers.
   pba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Page map storage.
   pba_ram #(
      .DEPTH (pba_pkg::MAX_PAGES),
      .AW    (pba_pkg::PAGE_W),
      .DW    (pba_pkg::ENTRY_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data)
   );

   // Operation sequencer.
   pba_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .mem         (mem),
      .mem_rd_data (mem_rd_data)
   );

`ifndef ASSERT_OFF
   // A failed operation never reports an address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ok) |-> (rsp_chan.result_address == '0))
      else $error("failed response carries an address");

   // Used count is managed minus free.
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
      (rsp_chan.pages_in_use == rsp_chan.pages_managed - rsp_chan.pages_free))
      else $error("used page count inconsistent");

   // Free pages never exceed managed pages.
   a_free_le_man: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pages_free <= rsp_chan.pages_managed))
      else $error("free pages exceed managed pages");

   // A request is never taken in the cycle after reset, while the map is cleared.
   a_clear_blocks: assert property (@(posedge clock)
      $fell(reset) |-> !req_chan.ready)
      else $error("request accepted during map clearing");
`endif

endmodule

### rtl/core/pba_ram.sv
module pba_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 2
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/pba_csr.sv
module pba_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pba_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pba_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pba_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output pba_pkg::cfg_type             cfg
);

   pba_pkg::cfg_type cfg_ff;
   logic [1:0]       idx;
   logic             wr_stb;

   assign idx        = csr_paddr[3:2];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register writes at the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_stb) begin
         case (idx)
            pba_pkg::REG_ENABLE: begin
               cfg_ff.enable <= csr_pwdata[0];
            end
            pba_pkg::REG_TOTAL: begin
               cfg_ff.total_pages <= csr_pwdata[pba_pkg::CNT_W-1:0];
            end
            pba_pkg::REG_RSV_FIRST: begin
               cfg_ff.reserved_first_page <= csr_pwdata[pba_pkg::PAGE_W-1:0];
            end
            pba_pkg::REG_RSV_COUNT: begin
               cfg_ff.reserved_page_count <= csr_pwdata[pba_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read data mux.
   always_comb begin
      case (idx)
         pba_pkg::REG_ENABLE: begin
            csr_prdata = pba_pkg::CSR_DW'(cfg_ff.enable);
         end
         pba_pkg::REG_TOTAL: begin
            csr_prdata = pba_pkg::CSR_DW'(cfg_ff.total_pages);
         end
         pba_pkg::REG_RSV_FIRST: begin
            csr_prdata = pba_pkg::CSR_DW'(cfg_ff.reserved_first_page);
         end
         pba_pkg::REG_RSV_COUNT: begin
            csr_prdata = pba_pkg::CSR_DW'(cfg_ff.reserved_page_count);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

### rtl/core/pba_engine.sv
module pba_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  pba_pkg::cfg_type                  cfg,
   pba_req_if.sink                           req,
   pba_rsp_if.source                         rsp,
   output pba_pkg::mem_req_type              mem,
   input  logic [pba_pkg::ENTRY_W-1:0]       mem_rd_data
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_EV, ST_WR, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      M_QUERY, M_ADD, M_ALLOC, M_FREE
   } mode_type;

   state_type                       state_ff, state_in;
   mode_type                        mode_ff, mode_in;
   logic                            pass_ff, pass_in;
   logic [pba_pkg::CNT_W-1:0]       p_ff, p_in;
   logic [pba_pkg::CNT_W-1:0]       last_ff, last_in;
   logic [pba_pkg::PAGE_W-1:0]      run_base_ff, run_base_in;
   logic [pba_pkg::CNT_W-1:0]       run_len_ff, run_len_in;
   logic [pba_pkg::CNT_W-1:0]       n_ff, n_in;
   pba_pkg::page_entry_type         wd_ff, wd_in;
   logic                            ok_ff, ok_in;
   logic [pba_pkg::ADDR_W-1:0]      res_addr_ff, res_addr_in;
   logic                            pused_ff, pused_in;
   logic [pba_pkg::CNT_W-1:0]       free_cnt_ff, free_cnt_in;
   logic [pba_pkg::CNT_W-1:0]       man_cnt_ff, man_cnt_in;
   logic [pba_pkg::PAGE_W-1:0]      sp_ff, sp_in;
   logic                            rv_ff, rv_in;
   logic                            r_ok_ff, r_ok_in;
   logic [pba_pkg::ADDR_W-1:0]      r_addr_ff, r_addr_in;
   logic                            r_pused_ff, r_pused_in;
   logic [pba_pkg::CNT_W-1:0]       r_free_ff, r_free_in;
   logic [pba_pkg::CNT_W-1:0]       r_man_ff, r_man_in;
   logic [pba_pkg::CNT_W-1:0]       r_used_ff, r_used_in;

   logic [pba_pkg::CNT_W-1:0]       lim;
   logic [pba_pkg::SUM_W-1:0]       start_sum, end_sum;
   logic [pba_pkg::BIGPG_W-1:0]     start_pg, end_pg, lim_big;
   logic [pba_pkg::CNT_W-1:0]       add_last;
   logic [pba_pkg::ADDR_W-pba_pkg::PAGE_SHIFT-1:0] addr_pg;
   logic                            addr_misaligned;
   logic                            pg_in_range;
   pba_pkg::page_entry_type         rd_entry;
   logic [pba_pkg::CNT_W:0]         rsv_end;
   logic                            p_reserved;
   logic [pba_pkg::CNT_W-1:0]       sp_ext;
   logic [pba_pkg::PAGE_W-1:0]      run_first;
   logic [pba_pkg::CNT_W-1:0]       run_next_len;
   logic [pba_pkg::CNT_W-1:0]       run_end;
   logic [pba_pkg::CNT_W-1:0]       p_next;
   logic [pba_pkg::CNT_W-1:0]       free_first;

   assign rd_entry = pba_pkg::page_entry_type'(mem_rd_data);

   // Page limit is the smaller of the register and the map size.
   assign lim = (cfg.total_pages > pba_pkg::CNT_W'(pba_pkg::MAX_PAGES)) ?
                pba_pkg::CNT_W'(pba_pkg::MAX_PAGES) : cfg.total_pages;
   assign lim_big = pba_pkg::BIGPG_W'(lim);
   assign sp_ext  = pba_pkg::CNT_W'(sp_ff);
   assign p_next  = p_ff + pba_pkg::CNT_W'(1);

   // Inward alignment of an added region, in page numbers.
   assign start_sum = {1'b0, req.byte_address} + pba_pkg::SUM_W'(pba_pkg::PAGE_BYTES - 1);
   assign end_sum   = {1'b0, req.byte_address} + {1'b0, req.region_length};
   assign start_pg  = start_sum[pba_pkg::SUM_W-1:pba_pkg::PAGE_SHIFT];
   assign end_pg    = end_sum[pba_pkg::SUM_W-1:pba_pkg::PAGE_SHIFT];
   assign add_last  = (end_pg > lim_big) ? lim : end_pg[pba_pkg::CNT_W-1:0];

   // Page number of a free or query address.
   assign addr_pg         = req.byte_address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
   assign addr_misaligned = req.byte_address[pba_pkg::PAGE_SHIFT-1:0] != '0;
   assign pg_in_range     = addr_pg < (pba_pkg::ADDR_W-pba_pkg::PAGE_SHIFT)'(lim);

   // Reserved span test for the current page.
   assign rsv_end    = (pba_pkg::CNT_W+1)'(cfg.reserved_first_page) +
                       (pba_pkg::CNT_W+1)'(cfg.reserved_page_count);
   assign p_reserved = (p_ff >= pba_pkg::CNT_W'(cfg.reserved_first_page)) &&
                       ((pba_pkg::CNT_W+1)'(p_ff) < rsv_end);

   // Run tracking during an allocation scan.
   assign run_first    = (run_len_ff == '0) ? p_ff[pba_pkg::PAGE_W-1:0] : run_base_ff;
   assign run_next_len = run_len_ff + pba_pkg::CNT_W'(1);
   assign run_end      = pba_pkg::CNT_W'(run_first) + n_ff;
   assign free_first   = last_ff - n_ff;

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rv_ff;
   assign rsp.ok             = r_ok_ff;
   assign rsp.result_address = r_addr_ff;
   assign rsp.page_used      = r_pused_ff;
   assign rsp.pages_free     = r_free_ff;
   assign rsp.pages_managed  = r_man_ff;
   assign rsp.pages_in_use   = r_used_ff;

   // Sequencer: one map entry is read, checked and written back per step.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pass_in      = pass_ff;
      p_in         = p_ff;
      last_in      = last_ff;
      run_base_in  = run_base_ff;
      run_len_in   = run_len_ff;
      n_in         = n_ff;
      wd_in        = wd_ff;
      ok_in        = ok_ff;
      res_addr_in  = res_addr_ff;
      pused_in     = pused_ff;
      free_cnt_in  = free_cnt_ff;
      man_cnt_in   = man_cnt_ff;
      sp_in        = sp_ff;
      rv_in        = rv_ff && !rsp.ready;
      r_ok_in      = r_ok_ff;
      r_addr_in    = r_addr_ff;
      r_pused_in   = r_pused_ff;
      r_free_in    = r_free_ff;
      r_man_in     = r_man_ff;
      r_used_in    = r_used_ff;
      mem          = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = p_ff[pba_pkg::PAGE_W-1:0];
            mem.wr_data = '{used: 1'b1, managed: 1'b0};
            p_in        = p_next;
            if (p_ff == pba_pkg::CNT_W'(pba_pkg::MAX_PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req.valid) begin
               ok_in       = 1'b0;
               res_addr_in = '0;
               pused_in    = (req.opcode == pba_pkg::OP_QUERY);
               n_in        = req.page_request;
               pass_in     = 1'b0;
               run_len_in  = '0;
               state_in    = ST_FIN;
               if (cfg.enable) begin
                  case (req.opcode)
                     pba_pkg::OP_QUERY: begin
                        mode_in = M_QUERY;
                        if (!addr_misaligned && pg_in_range) begin
                           p_in     = addr_pg[pba_pkg::CNT_W-1:0];
                           last_in  = addr_pg[pba_pkg::CNT_W-1:0] + pba_pkg::CNT_W'(1);
                           state_in = ST_RD;
                        end
                     end
                     pba_pkg::OP_ADD: begin
                        mode_in = M_ADD;
                        if (end_pg > start_pg) begin
                           ok_in = 1'b1;
                           if (start_pg < pba_pkg::BIGPG_W'(add_last)) begin
                              p_in     = start_pg[pba_pkg::CNT_W-1:0];
                              last_in  = add_last;
                              state_in = ST_RD;
                           end
                        end
                     end
                     pba_pkg::OP_ALLOC: begin
                        mode_in = M_ALLOC;
                        if (req.page_request != '0 && req.page_request <= free_cnt_ff) begin
                           p_in     = sp_ext;
                           last_in  = lim;
                           state_in = ST_RD;
                        end
                     end
                     pba_pkg::OP_FREE: begin
                        mode_in = M_FREE;
                        if (req.page_request != '0 && !addr_misaligned &&
                            addr_pg != '0 && pg_in_range &&
                            req.page_request <= lim - addr_pg[pba_pkg::CNT_W-1:0]) begin
                           p_in     = addr_pg[pba_pkg::CNT_W-1:0];
                           last_in  = addr_pg[pba_pkg::CNT_W-1:0] + req.page_request;
                           state_in = ST_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_RD: begin
            if (p_ff >= last_ff) begin
               // End of the scanned range.
               case (mode_ff)
                  M_ALLOC: begin
                     if (!pass_ff) begin
                        pass_in    = 1'b1;
                        p_in       = pba_pkg::CNT_W'(1);
                        last_in    = (sp_ext < lim) ? sp_ext : lim;
                        run_len_in = '0;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  M_FREE: begin
                     free_cnt_in = free_cnt_ff + n_ff;
                     if (free_first < sp_ext) begin
                        sp_in = free_first[pba_pkg::PAGE_W-1:0];
                     end
                     ok_in    = 1'b1;
                     wd_in    = '{used: 1'b0, managed: 1'b1};
                     p_in     = free_first;
                     state_in = ST_WR;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = p_ff[pba_pkg::PAGE_W-1:0];
               state_in    = ST_EV;
            end
         end

         ST_EV: begin
            p_in     = p_next;
            state_in = ST_RD;
            case (mode_ff)
               M_QUERY: begin
                  ok_in    = 1'b1;
                  pused_in = rd_entry.used;
                  state_in = ST_FIN;
               end
               M_ADD: begin
                  if (!rd_entry.managed) begin
                     mem.wr_en        = 1'b1;
                     mem.wr_addr      = p_ff[pba_pkg::PAGE_W-1:0];
                     mem.wr_data.managed = 1'b1;
                     mem.wr_data.used = (p_ff == '0) || p_reserved;
                     man_cnt_in       = man_cnt_ff + pba_pkg::CNT_W'(1);
                     if (!((p_ff == '0) || p_reserved)) begin
                        free_cnt_in = free_cnt_ff + pba_pkg::CNT_W'(1);
                     end
                  end
               end
               M_ALLOC: begin
                  if (rd_entry.used) begin
                     run_len_in = '0;
                  end else if (run_next_len == n_ff) begin
                     // Run complete: commit and mark it.
                     free_cnt_in = free_cnt_ff - n_ff;
                     sp_in       = (run_end >= lim) ? pba_pkg::PAGE_W'(1) :
                                   run_end[pba_pkg::PAGE_W-1:0];
                     res_addr_in = pba_pkg::ADDR_W'(run_first) << pba_pkg::PAGE_SHIFT;
                     ok_in       = 1'b1;
                     wd_in       = '{used: 1'b1, managed: 1'b1};
                     p_in        = pba_pkg::CNT_W'(run_first);
                     last_in     = run_end;
                     state_in    = ST_WR;
                  end else begin
                     run_base_in = run_first;
                     run_len_in  = run_next_len;
                  end
               end
               M_FREE: begin
                  if (!rd_entry.managed || p_reserved || !rd_entry.used) begin
                     state_in = ST_FIN;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_WR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = p_ff[pba_pkg::PAGE_W-1:0];
            mem.wr_data = wd_ff;
            p_in        = p_next;
            if (p_next >= last_ff) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (!rv_ff || rsp.ready) begin
               rv_in      = 1'b1;
               r_ok_in    = ok_ff;
               r_addr_in  = res_addr_ff;
               r_pused_in = pused_ff;
               r_free_in  = cfg.enable ? free_cnt_ff : '0;
               r_man_in   = cfg.enable ? man_cnt_ff : '0;
               r_used_in  = cfg.enable ? (man_cnt_ff - free_cnt_ff) : '0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         mode_ff     <= M_QUERY;
         pass_ff     <= 1'b0;
         p_ff        <= '0;
         free_cnt_ff <= '0;
         man_cnt_ff  <= '0;
         sp_ff       <= pba_pkg::PAGE_W'(1);
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         pass_ff     <= pass_in;
         p_ff        <= p_in;
         free_cnt_ff <= free_cnt_in;
         man_cnt_ff  <= man_cnt_in;
         sp_ff       <= sp_in;
         rv_ff       <= rv_in;
      end
      last_ff      <= last_in;
      run_base_ff  <= run_base_in;
      run_len_ff   <= run_len_in;
      n_ff         <= n_in;
      wd_ff        <= wd_in;
      ok_ff        <= ok_in;
      res_addr_ff  <= res_addr_in;
      pused_ff     <= pused_in;
      r_ok_ff      <= r_ok_in;
      r_addr_ff    <= r_addr_in;
      r_pused_ff   <= r_pused_in;
      r_free_ff    <= r_free_in;
      r_man_ff     <= r_man_in;
      r_used_ff    <= r_used_in;
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int N_DISABLED     = 2;

   typedef struct {
      logic [1:0]                 opcode;
      logic [pba_pkg::ADDR_W-1:0] byte_address;
      logic [pba_pkg::ADDR_W-1:0] region_length;
      logic [pba_pkg::CNT_W-1:0]  page_request;
   } page_cmd_type;

   typedef struct {
      bit                         ok;
      bit [pba_pkg::ADDR_W-1:0]   result_address;
      bit                         page_used;
      bit [pba_pkg::CNT_W-1:0]    pages_free;
      bit [pba_pkg::CNT_W-1:0]    pages_managed;
      bit [pba_pkg::CNT_W-1:0]    pages_in_use;
   } page_answer_type;

   // One row of the directed table; typed rows carry their own answer.
   typedef struct {
      page_cmd_type    cmd;
      bit              typed;
      page_answer_type answer;
   } directed_row_type;

   typedef struct {
      int unsigned first;
      int unsigned count;
   } live_run_type;

   logic clock;
   logic reset;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [pba_pkg::CSR_AW-1:0]   csr_paddr;
   logic [pba_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [pba_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   pba_req_if req_bus();
   pba_rsp_if rsp_bus();

   page_bitmap_next_fit_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the page maps, counters and registers.
   bit          shadow_used [pba_pkg::MAX_PAGES];
   bit          shadow_managed [pba_pkg::MAX_PAGES];
   int unsigned shadow_free;
   int unsigned shadow_managed_cnt;
   int unsigned shadow_pointer;
   bit          cfg_enable;
   int unsigned cfg_total;
   int unsigned cfg_rsv_first;
   int unsigned cfg_rsv_count;

   page_answer_type pending_answers[$];
   live_run_type    live_runs[$];
   int              error_count = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   bit              holdoff_request = 0;
   int              quiet_cycles = 0;

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned page_limit();
      return (cfg_total < pba_pkg::MAX_PAGES) ? cfg_total : pba_pkg::MAX_PAGES;
   endfunction

   function automatic bit page_reserved(longint unsigned page);
      return page >= cfg_rsv_first && page < longint'(cfg_rsv_first) + cfg_rsv_count;
   endfunction

   // Apply one command to the shadow state and return the expected answer.
   function automatic page_answer_type apply_page_cmd(page_cmd_type cmd);
      page_answer_type ans;
      longint unsigned lim, first, last, start_b, end_b, p, k, b, e, run_base, run_len, n;
      bit              hit;
      ans = '{default: 0};
      lim = page_limit();
      n = cmd.page_request;
      run_base = 0;
      if (cmd.opcode == pba_pkg::OP_QUERY) begin
         ans.page_used = 1;
         if (cfg_enable && cmd.byte_address[pba_pkg::PAGE_SHIFT-1:0] == 0) begin
            p = cmd.byte_address >> pba_pkg::PAGE_SHIFT;
            if (p < lim) begin
               ans.ok = 1;
               ans.page_used = shadow_used[p];
            end
         end
      end else if (cfg_enable && cmd.opcode == pba_pkg::OP_ADD) begin
         start_b = (longint'(cmd.byte_address) + pba_pkg::PAGE_BYTES - 1) &
                   ~longint'(pba_pkg::PAGE_BYTES - 1);
         end_b = (longint'(cmd.byte_address) + cmd.region_length) &
                 ~longint'(pba_pkg::PAGE_BYTES - 1);
         if (end_b > start_b) begin
            ans.ok = 1;
            first = start_b >> pba_pkg::PAGE_SHIFT;
            last = end_b >> pba_pkg::PAGE_SHIFT;
            if (last > lim) last = lim;
            for (p = first; p < last; p++) begin
               if (!shadow_managed[p]) begin
                  shadow_managed[p] = 1;
                  shadow_managed_cnt++;
                  if (p != 0 && !page_reserved(p)) begin
                     shadow_used[p] = 0;
                     shadow_free++;
                  end
               end
            end
         end
      end else if (cfg_enable && cmd.opcode == pba_pkg::OP_ALLOC) begin
         hit = 0;
         if (n != 0 && n <= shadow_free) begin
            // Next fit: from the pointer to the limit, then from page 1 to the pointer.
            for (int pass = 0; pass < 2 && !hit; pass++) begin
               b = (pass == 0) ? shadow_pointer : 1;
               e = (pass == 0) ? lim : shadow_pointer;
               if (e > lim) e = lim;
               run_len = 0;
               for (p = b; p < e && !hit; p++) begin
                  if (shadow_used[p]) begin
                     run_len = 0;
                  end else begin
                     if (run_len == 0) run_base = p;
                     run_len++;
                     if (run_len == n) hit = 1;
                  end
               end
            end
         end
         if (hit) begin
            for (k = run_base; k < run_base + n; k++) shadow_used[k] = 1;
            shadow_free -= 32'(n);
            shadow_pointer = 32'(run_base + n);
            if (shadow_pointer >= lim) shadow_pointer = 1;
            ans.ok = 1;
            ans.result_address = pba_pkg::ADDR_W'(run_base << pba_pkg::PAGE_SHIFT);
         end
      end else if (cfg_enable && cmd.opcode == pba_pkg::OP_FREE) begin
         first = cmd.byte_address >> pba_pkg::PAGE_SHIFT;
         hit = n != 0 && cmd.byte_address[pba_pkg::PAGE_SHIFT-1:0] == 0 && first != 0 &&
               first < lim && n <= lim - first;
         if (hit) begin
            for (p = first; p < first + n; p++)
               if (!shadow_managed[p] || page_reserved(p) || !shadow_used[p]) hit = 0;
         end
         if (hit) begin
            for (p = first; p < first + n; p++) shadow_used[p] = 0;
            shadow_free += 32'(n);
            if (first < shadow_pointer) shadow_pointer = 32'(first);
            ans.ok = 1;
         end
      end
      if (cfg_enable) begin
         ans.pages_free = pba_pkg::CNT_W'(shadow_free);
         ans.pages_managed = pba_pkg::CNT_W'(shadow_managed_cnt);
         ans.pages_in_use = pba_pkg::CNT_W'(shadow_managed_cnt - shadow_free);
      end
      return ans;
   endfunction

   // Register write over the configuration port; called at a falling edge.
   task automatic write_reg(logic [1:0] index, int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= pba_pkg::CSR_AW'(index) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         pba_pkg::REG_ENABLE: begin
            cfg_enable = value[0];
         end
         pba_pkg::REG_TOTAL: begin
            cfg_total = value & 13'h1FFF;
         end
         pba_pkg::REG_RSV_FIRST: begin
            cfg_rsv_first = value & 12'hFFF;
         end
         pba_pkg::REG_RSV_COUNT: begin
            cfg_rsv_count = value & 13'h1FFF;
         end
         default: begin
         end
      endcase
   endtask

   // Wait at a falling edge until every expected answer has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_geometry(bit en, int unsigned total, int unsigned rfirst,
                               int unsigned rcount);
      write_reg(pba_pkg::REG_ENABLE, en);
      write_reg(pba_pkg::REG_TOTAL, total);
      write_reg(pba_pkg::REG_RSV_FIRST, rfirst);
      write_reg(pba_pkg::REG_RSV_COUNT, rcount);
   endtask

   // Offer one command, wait for its transfer, then record the expected answer.
   task automatic send_cmd(page_cmd_type cmd, bit typed, page_answer_type typed_answer);
      page_answer_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= cmd.opcode;
      req_bus.byte_address <= cmd.byte_address;
      req_bus.region_length <= cmd.region_length;
      req_bus.page_request <= cmd.page_request;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_page_cmd(cmd);
      if (typed) begin
         pending_answers.push_back(typed_answer);
      end else begin
         pending_answers.push_back(predicted);
      end
      if (cmd.opcode == pba_pkg::OP_ALLOC && predicted.ok) begin
         live_runs.push_back('{32'(predicted.result_address >> pba_pkg::PAGE_SHIFT),
                               32'(cmd.page_request)});
      end
      @(negedge clock);
   endtask

   // Random command: mostly allocate and free of live runs, some queries, adds and noise.
   task automatic send_random(int unsigned limit_pages);
      page_cmd_type    cmd;
      page_answer_type none;
      int              pick;
      int              idx;
      live_run_type    run;
      none = '{default: 0};
      cmd.opcode = pba_pkg::OP_ALLOC;
      cmd.byte_address = pba_pkg::ADDR_W'({$urandom, $urandom});
      cmd.region_length = pba_pkg::ADDR_W'({$urandom, $urandom});
      cmd.page_request = pba_pkg::CNT_W'($urandom_range(1, 8));
      pick = $urandom_range(99);
      if (pick < 35) begin
         if ($urandom_range(9) == 0) begin
            cmd.page_request = pba_pkg::CNT_W'($urandom_range(0, 4096));
         end
      end else if (pick < 65 && live_runs.size() != 0) begin
         cmd.opcode = pba_pkg::OP_FREE;
         idx = $urandom_range(live_runs.size() - 1);
         run = live_runs[idx];
         cmd.byte_address = pba_pkg::ADDR_W'(run.first) << pba_pkg::PAGE_SHIFT;
         cmd.page_request = pba_pkg::CNT_W'(run.count);
         // Most frees release the whole run; a few repeat or stretch it.
         if ($urandom_range(9) == 0) begin
            cmd.page_request = pba_pkg::CNT_W'(run.count + 1);
         end else if ($urandom_range(9) != 0) begin
            live_runs.delete(idx);
         end
      end else if (pick < 80) begin
         cmd.opcode = pba_pkg::OP_QUERY;
         cmd.byte_address = pba_pkg::ADDR_W'($urandom_range(limit_pages)) <<
                            pba_pkg::PAGE_SHIFT;
      end else if (pick < 90) begin
         cmd.opcode = pba_pkg::OP_ADD;
         cmd.byte_address = (pba_pkg::ADDR_W'($urandom_range(limit_pages)) <<
                             pba_pkg::PAGE_SHIFT) +
                            pba_pkg::ADDR_W'($urandom_range(3) * 1000);
         cmd.region_length = pba_pkg::ADDR_W'($urandom_range(limit_pages)) <<
                             pba_pkg::PAGE_SHIFT;
      end else begin
         cmd.opcode = 2'($urandom_range(3));
         cmd.page_request = pba_pkg::CNT_W'($urandom);
      end
      send_cmd(cmd, 0, none);
   endtask

   task automatic random_phase(int count, int unsigned limit_pages);
      repeat (count) send_random(limit_pages);
   endtask

   task automatic check_field(string name, longint unsigned exp, longint unsigned act);
      if (exp !== act) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp, act);
         error_count++;
      end
   endtask

   // Response checking at the rising edge.
   always @(posedge clock) begin
      page_answer_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected response transfer", $time);
            error_count++;
         end else begin
            exp = pending_answers.pop_front();
            check_field("ok", exp.ok, rsp_bus.ok);
            check_field("result_address", exp.result_address, rsp_bus.result_address);
            check_field("page_used", exp.page_used, rsp_bus.page_used);
            check_field("pages_free", exp.pages_free, rsp_bus.pages_free);
            check_field("pages_managed", exp.pages_managed, rsp_bus.pages_managed);
            check_field("pages_in_use", exp.pages_in_use, rsp_bus.pages_in_use);
         end
      end
   end

   // Receiver ready, with random stalls and an occasional long hold-off.
   always @(negedge clock) begin
      int holdoff_left;
      if (holdoff_request) begin
         holdoff_request = 0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   directed_row_type directed[$];

   task automatic add_row(logic [1:0] op, logic [pba_pkg::ADDR_W-1:0] addr,
                          logic [pba_pkg::ADDR_W-1:0] len,
                          logic [pba_pkg::CNT_W-1:0] req, bit typed, bit ok, bit pused);
      directed_row_type row;
      row.cmd = '{op, addr, len, req};
      row.typed = typed;
      row.answer = '{default: 0};
      row.answer.ok = ok;
      row.answer.page_used = pused;
      directed.push_back(row);
   endtask

   initial begin
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = pba_pkg::OP_QUERY;
      req_bus.byte_address = '0;
      req_bus.region_length = '0;
      req_bus.page_request = '0;
      rsp_bus.ready = 1'b0;
      foreach (shadow_used[i]) begin
         shadow_used[i] = 1;
         shadow_managed[i] = 0;
      end
      shadow_free = 0;
      shadow_managed_cnt = 0;
      shadow_pointer = 1;
      cfg_enable = 0;
      cfg_total = 0;
      cfg_rsv_first = 0;
      cfg_rsv_count = 0;

      // Disabled block, then empty map with 64 pages and a reserved span at 10..13.
      add_row(pba_pkg::OP_QUERY, 48'h4000, 0, 0, 1, 0, 1);
      add_row(pba_pkg::OP_ADD, 0, 48'h40000, 0, 1, 0, 0);
      add_row(pba_pkg::OP_ALLOC, 0, 0, 0, 1, 0, 0);
      add_row(pba_pkg::OP_FREE, 0, 0, 1, 1, 0, 0);
      add_row(pba_pkg::OP_QUERY, 48'h123, 0, 0, 1, 0, 1);
      add_row(pba_pkg::OP_QUERY, 64 << pba_pkg::PAGE_SHIFT, 0, 0, 1, 0, 1);
      add_row(pba_pkg::OP_ADD, 1, 4096, 0, 1, 0, 0);
      add_row(pba_pkg::OP_ADD, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0);
      add_row(pba_pkg::OP_ADD, 0, 8 << pba_pkg::PAGE_SHIFT, 0, 0, 0, 0);
      add_row(pba_pkg::OP_ALLOC, 0, 0, 4096, 0, 0, 0);
      add_row(pba_pkg::OP_ALLOC, 0, 0, 1, 0, 0, 0);
      add_row(pba_pkg::OP_ALLOC, 0, 0, 50, 0, 0, 0);
      add_row(pba_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 10 << pba_pkg::PAGE_SHIFT, 0, 1, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 14 << pba_pkg::PAGE_SHIFT, 0, 50, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 64 << pba_pkg::PAGE_SHIFT, 0, 1, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 14 << pba_pkg::PAGE_SHIFT, 0, 0, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 48'h1001, 0, 1, 0, 0, 0);
      add_row(pba_pkg::OP_QUERY, 48'hFFFF_FFFF_F000, 0, 0, 0, 0, 0);
      add_row(pba_pkg::OP_FREE, 63 << pba_pkg::PAGE_SHIFT, 0, 2, 0, 0, 0);
      add_row(pba_pkg::OP_ALLOC, 0, 0, 13'h1FFF, 0, 0, 0);

      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (i == N_DISABLED) begin
            drain();
            set_geometry(1, 64, 10, 4);
         end
         send_cmd(directed[i].cmd, directed[i].typed, directed[i].answer);
      end

      // No idling; the receiver holds off for a long stretch partway through.
      random_phase(10, 64);
      holdoff_request = 1;
      random_phase(20, 64);

      // Sender idle often, no reserved span.
      drain();
      set_geometry(1, 200, 0, 0);
      sender_idle_pct = 66;
      send_cmd('{pba_pkg::OP_ADD, 48'h800, 48'h1_0000_0000, 0}, 0, '{default: 0});
      random_phase(30, 200);

      // Full map size: limit saturates, reserved span runs off the end.
      drain();
      set_geometry(1, 13'h1FFF, 4095, 4096);
      sender_idle_pct = 0;
      receiver_stall_pct = 66;
      send_cmd('{pba_pkg::OP_ADD, 0, 48'hFFFF_FFFF_FFFF, 0}, 0, '{default: 0});
      random_phase(25, 4096);

      // Disabled with a zero page limit.
      drain();
      set_geometry(0, 0, 0, 0);
      random_phase(8, 64);

      // Both sides idle; reserved span covers page 0 only.
      drain();
      set_geometry(1, 100, 0, 1);
      sender_idle_pct = 34;
      receiver_stall_pct = 34;
      random_phase(30, 100);

      drain();
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
